// ===== rtl/cau_pkg.sv =====
// ============================================================================
// cau_pkg: shared types, constants and helpers of the complex arithmetic unit
// Fixed-point word formats, opcode and status codes, the pipeline item
// structs and the saturation helpers used across stages.
// ============================================================================
package cau_pkg;

    localparam int DW   = 32;             // word width
    localparam int FB   = 16;             // fraction bits
    localparam int QW   = DW + 1;         // quotient / root bits, one per stage
    localparam int DENW = 2 * DW;         // divisor and sum-of-squares width
    localparam int NUMW = 2 * DW + 2 * FB + 2;  // dividend width
    localparam int SRW  = QW + 3;         // root remainder width

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_RECIP = 3'd5,
        OP_SCALE = 3'd6,
        OP_MOD   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef logic signed [DW-1:0]     word_t;
    typedef logic signed [2*DW-1:0]   prod_t;
    typedef logic signed [2*DW:0]     wide_t;
    typedef logic signed [NUMW-1:0]   num_t;
    typedef logic        [NUMW-1:0]   mag_t;
    typedef logic        [DENW-1:0]   den_t;
    typedef logic        [QW-1:0]     quo_t;
    typedef logic        [2*QW-1:0]   sqn_t;
    typedef logic        [SRW-1:0]    srem_t;

    localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam wide_t WIDE_MAX = {{(DW+2){1'b0}}, {(DW-1){1'b1}}};
    localparam wide_t WIDE_MIN = {{(DW+2){1'b1}}, {(DW-1){1'b0}}};
    localparam quo_t  QPOS_MAX = {2'b00, {(DW-1){1'b1}}};
    localparam quo_t  QNEG_MAX = {2'b01, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [2:0] opcode;
        word_t      a_re;
        word_t      a_im;
        word_t      b_re;
        word_t      b_im;
        word_t      scalar;
    } cau_in_t;

    typedef struct packed {
        word_t      res_re;
        word_t      res_im;
        logic [1:0] status;
    } cau_out_t;

    typedef struct packed {
        word_t val;
        logic  flag;
    } sat_t;

    // item as it travels through the divide / root stages
    typedef struct packed {
        op_t   op;
        word_t res_re;      // result of the operations that bypass the recurrences
        word_t res_im;
        logic  sat;
        logic  divz;
        logic  neg_re;
        logic  neg_im;
        logic  ovf_re;
        logic  ovf_im;
        den_t  den;
        den_t  rem_re;
        den_t  rem_im;
        quo_t  nlo_re;
        quo_t  nlo_im;
        quo_t  q_re;
        quo_t  q_im;
        sqn_t  sq_n;
        srem_t sq_rem;
        quo_t  sq_root;
    } iter_t;

    function automatic sat_t sat_wide(input wide_t v);
        sat_t r;
        if (v > WIDE_MAX)
        begin
            r.val  = WORD_MAX;
            r.flag = 1'b1;
        end
        else if (v < WIDE_MIN)
        begin
            r.val  = WORD_MIN;
            r.flag = 1'b1;
        end
        else
        begin
            r.val  = v[DW-1:0];
            r.flag = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t sat_quo(input logic neg, input logic ovf, input quo_t q);
        sat_t r;
        quo_t nq;
        nq = -q;
        if (!neg)
        begin
            if (ovf || q > QPOS_MAX)
            begin
                r.val  = WORD_MAX;
                r.flag = 1'b1;
            end
            else
            begin
                r.val  = q[DW-1:0];
                r.flag = 1'b0;
            end
        end
        else
        begin
            if (ovf || q > QNEG_MAX)
            begin
                r.val  = WORD_MIN;
                r.flag = 1'b1;
            end
            else
            begin
                r.val  = nq[DW-1:0];
                r.flag = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/cau_prep.sv =====
// ============================================================================
// cau_prep: front stages of the complex arithmetic unit
// Products, sums and direct results, dividend magnitude and the
// set-up of the divide and root recurrences, over four register stages.
// ============================================================================
module cau_prep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  cau_pkg::cau_in_t in_item,
    output logic             out_valid,
    output cau_pkg::iter_t   out_item
);
    import cau_pkg::*;

    op_t   op_in;
    word_t mb0;
    word_t mb1;
    word_t sq_x;
    word_t sq_y;
    sat_t  s_re;
    sat_t  s_im;

    logic  p1_v_reg;
    op_t   p1_op_reg;
    word_t p1_ar_reg;
    word_t p1_ai_reg;
    prod_t p1_m0_reg, p1_m1_reg, p1_m2_reg, p1_m3_reg, p1_m4_reg, p1_m5_reg;
    word_t p1_re_reg;
    word_t p1_im_reg;
    logic  p1_sat_reg;

    sat_t  r_re;
    sat_t  r_im;
    wide_t mre;
    wide_t mim;
    num_t  num_re_next;
    num_t  num_im_next;

    logic  p2_v_reg;
    op_t   p2_op_reg;
    word_t p2_re_reg;
    word_t p2_im_reg;
    logic  p2_sat_reg;
    num_t  p2_nre_reg;
    num_t  p2_nim_reg;
    den_t  p2_den_reg;

    logic  p3_v_reg;
    op_t   p3_op_reg;
    word_t p3_re_reg;
    word_t p3_im_reg;
    logic  p3_sat_reg;
    logic  p3_neg_re_reg;
    logic  p3_neg_im_reg;
    mag_t  p3_mre_reg;
    mag_t  p3_mim_reg;
    den_t  p3_den_reg;

    mag_t  hi_re;
    mag_t  hi_im;
    iter_t it_next;
    logic  p4_v_reg;
    iter_t p4_reg;

    // stage 1: operand select, products, add / sub / conjugate
    assign op_in = op_t'(in_item.opcode);

    always_comb
    begin
        mb0  = (op_in == OP_SCALE) ? in_item.scalar : in_item.b_re;
        mb1  = (op_in == OP_SCALE) ? in_item.scalar : in_item.b_im;
        sq_x = (op_in == OP_DIV) ? in_item.b_re : in_item.a_re;
        sq_y = (op_in == OP_DIV) ? in_item.b_im : in_item.a_im;
        case (op_in)
            OP_ADD:
            begin
                s_re = sat_wide(wide_t'(in_item.a_re) + wide_t'(in_item.b_re));
                s_im = sat_wide(wide_t'(in_item.a_im) + wide_t'(in_item.b_im));
            end
            OP_SUB:
            begin
                s_re = sat_wide(wide_t'(in_item.a_re) - wide_t'(in_item.b_re));
                s_im = sat_wide(wide_t'(in_item.a_im) - wide_t'(in_item.b_im));
            end
            OP_CONJ:
            begin
                s_re = sat_wide(wide_t'(in_item.a_re));
                s_im = sat_wide(-wide_t'(in_item.a_im));
            end
            default:
            begin
                s_re = '0;
                s_im = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_op_reg  <= op_in;
            p1_ar_reg  <= in_item.a_re;
            p1_ai_reg  <= in_item.a_im;
            p1_m0_reg  <= in_item.a_re * mb0;
            p1_m1_reg  <= in_item.a_im * mb1;
            p1_m2_reg  <= in_item.a_re * in_item.b_im;
            p1_m3_reg  <= in_item.a_im * in_item.b_re;
            p1_m4_reg  <= sq_x * sq_x;
            p1_m5_reg  <= sq_y * sq_y;
            p1_re_reg  <= s_re.val;
            p1_im_reg  <= s_im.val;
            p1_sat_reg <= s_re.flag | s_im.flag;
        end
    end

    // stage 2: product sums, rescale of mul / scale, dividend and divisor
    always_comb
    begin
        mre = wide_t'(p1_m0_reg) - wide_t'(p1_m1_reg);
        mim = wide_t'(p1_m2_reg) + wide_t'(p1_m3_reg);
        case (p1_op_reg)
            OP_MUL:
            begin
                r_re = sat_wide(mre >>> FB);
                r_im = sat_wide(mim >>> FB);
            end
            OP_SCALE:
            begin
                r_re = sat_wide(wide_t'(p1_m0_reg) >>> FB);
                r_im = sat_wide(wide_t'(p1_m1_reg) >>> FB);
            end
            default:
            begin
                r_re.val  = p1_re_reg;
                r_re.flag = p1_sat_reg;
                r_im.val  = p1_im_reg;
                r_im.flag = 1'b0;
            end
        endcase
        if (p1_op_reg == OP_RECIP)
        begin
            num_re_next = num_t'(p1_ar_reg) <<< (2 * FB);
            num_im_next = (-num_t'(p1_ai_reg)) <<< (2 * FB);
        end
        else
        begin
            num_re_next = num_t'(wide_t'(p1_m0_reg) + wide_t'(p1_m1_reg)) <<< FB;
            num_im_next = num_t'(wide_t'(p1_m3_reg) - wide_t'(p1_m2_reg)) <<< FB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_op_reg  <= p1_op_reg;
            p2_re_reg  <= r_re.val;
            p2_im_reg  <= r_im.val;
            p2_sat_reg <= r_re.flag | r_im.flag;
            p2_nre_reg <= num_re_next;
            p2_nim_reg <= num_im_next;
            p2_den_reg <= den_t'(p1_m4_reg) + den_t'(p1_m5_reg);
        end
    end

    // stage 3: sign and magnitude of the dividends
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_op_reg     <= p2_op_reg;
            p3_re_reg     <= p2_re_reg;
            p3_im_reg     <= p2_im_reg;
            p3_sat_reg    <= p2_sat_reg;
            p3_neg_re_reg <= p2_nre_reg[NUMW-1];
            p3_neg_im_reg <= p2_nim_reg[NUMW-1];
            p3_mre_reg    <= p2_nre_reg[NUMW-1] ? mag_t'(-p2_nre_reg) : mag_t'(p2_nre_reg);
            p3_mim_reg    <= p2_nim_reg[NUMW-1] ? mag_t'(-p2_nim_reg) : mag_t'(p2_nim_reg);
            p3_den_reg    <= p2_den_reg;
        end
    end

    // stage 4: overflow check on the quotient, seed the recurrences
    always_comb
    begin
        hi_re           = p3_mre_reg >> QW;
        hi_im           = p3_mim_reg >> QW;
        it_next.op      = p3_op_reg;
        it_next.res_re  = p3_re_reg;
        it_next.res_im  = p3_im_reg;
        it_next.sat     = p3_sat_reg;
        it_next.divz    = (p3_den_reg == '0);
        it_next.neg_re  = p3_neg_re_reg;
        it_next.neg_im  = p3_neg_im_reg;
        it_next.ovf_re  = (hi_re >= mag_t'(p3_den_reg));
        it_next.ovf_im  = (hi_im >= mag_t'(p3_den_reg));
        it_next.den     = p3_den_reg;
        it_next.rem_re  = hi_re[DENW-1:0];
        it_next.rem_im  = hi_im[DENW-1:0];
        it_next.nlo_re  = p3_mre_reg[QW-1:0];
        it_next.nlo_im  = p3_mim_reg[QW-1:0];
        it_next.q_re    = '0;
        it_next.q_im    = '0;
        it_next.sq_n    = sqn_t'(p3_den_reg);
        it_next.sq_rem  = '0;
        it_next.sq_root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg <= it_next;
        end
    end

    assign out_valid = p4_v_reg;
    assign out_item  = p4_reg;

endmodule

// ===== rtl/cau_iter.sv =====
// ============================================================================
// cau_iter: one stage of the divide and square-root recurrences
// Retires one quotient bit on each of the two divide lanes and one root
// bit on the square-root lane, then registers the item.
// ============================================================================
module cau_iter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cau_pkg::iter_t in_item,
    output logic           out_valid,
    output cau_pkg::iter_t out_item
);
    import cau_pkg::*;

    logic [DENW:0] r2_re;
    logic [DENW:0] r2_im;
    logic [DENW:0] dv;
    srem_t         cur;
    srem_t         trial;
    iter_t         nx;
    logic          v_reg;
    iter_t         item_reg;

    always_comb
    begin
        nx    = in_item;
        dv    = {1'b0, in_item.den};
        r2_re = {in_item.rem_re, in_item.nlo_re[QW-1]};
        r2_im = {in_item.rem_im, in_item.nlo_im[QW-1]};
        nx.nlo_re = in_item.nlo_re << 1;
        nx.nlo_im = in_item.nlo_im << 1;
        // restoring step, real lane
        if (r2_re >= dv)
        begin
            nx.rem_re = DENW'(r2_re - dv);
            nx.q_re   = {in_item.q_re[QW-2:0], 1'b1};
        end
        else
        begin
            nx.rem_re = r2_re[DENW-1:0];
            nx.q_re   = {in_item.q_re[QW-2:0], 1'b0};
        end
        // restoring step, imaginary lane
        if (r2_im >= dv)
        begin
            nx.rem_im = DENW'(r2_im - dv);
            nx.q_im   = {in_item.q_im[QW-2:0], 1'b1};
        end
        else
        begin
            nx.rem_im = r2_im[DENW-1:0];
            nx.q_im   = {in_item.q_im[QW-2:0], 1'b0};
        end
        // digit-by-digit root, two radicand bits per step
        cur     = {in_item.sq_rem[SRW-3:0], in_item.sq_n[2*QW-1 -: 2]};
        trial   = SRW'({in_item.sq_root, 2'b01});
        nx.sq_n = in_item.sq_n << 2;
        if (cur >= trial)
        begin
            nx.sq_rem  = cur - trial;
            nx.sq_root = {in_item.sq_root[QW-2:0], 1'b1};
        end
        else
        begin
            nx.sq_rem  = cur;
            nx.sq_root = {in_item.sq_root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= nx;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/cau_post.sv =====
// ============================================================================
// cau_post: result stage of the complex arithmetic unit
// Signs and saturates quotients and the root, picks the result by opcode
// and forms the status.
// ============================================================================
module cau_post (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::iter_t    in_item,
    output logic              out_valid,
    output cau_pkg::cau_out_t out_item
);
    import cau_pkg::*;

    sat_t     qre;
    sat_t     qim;
    cau_out_t res_next;
    logic     v_reg;
    cau_out_t res_reg;

    always_comb
    begin
        qre = sat_quo(in_item.neg_re, in_item.ovf_re, in_item.q_re);
        qim = sat_quo(in_item.neg_im, in_item.ovf_im, in_item.q_im);
        case (in_item.op)
            OP_DIV, OP_RECIP:
            begin
                if (in_item.divz)
                begin
                    res_next.res_re = '0;
                    res_next.res_im = '0;
                    res_next.status = ST_DIVZ;
                end
                else
                begin
                    res_next.res_re = qre.val;
                    res_next.res_im = qim.val;
                    res_next.status = (qre.flag | qim.flag) ? ST_SAT : ST_OK;
                end
            end
            OP_MOD:
            begin
                res_next.res_im = '0;
                if (in_item.sq_root > QPOS_MAX)
                begin
                    res_next.res_re = WORD_MAX;
                    res_next.status = ST_SAT;
                end
                else
                begin
                    res_next.res_re = in_item.sq_root[DW-1:0];
                    res_next.status = ST_OK;
                end
            end
            default:
            begin
                res_next.res_re = in_item.res_re;
                res_next.res_im = in_item.res_im;
                res_next.status = in_item.sat ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg;
    assign out_item  = res_reg;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// ============================================================================
// complex_arithmetic_unit: pipelined Q16.16 complex arithmetic
// Add, subtract, multiply, divide, conjugate, reciprocal, scale and modulus
// on signed fixed-point complex operands, with saturation and status.
// ============================================================================
// Usage: one item per clock is accepted while req_stall is low, and one
// result per clock leaves while rsp_stall is low. An accepted item passes
// four front stages (products, sums, dividend magnitude, recurrence seed),
// QW = DW + 1 stages of the divide and square-root recurrences (one
// quotient bit per lane and one root bit each), one result stage and the
// output register before its result shows on rsp. Every opcode walks the
// same path, so results leave in issue order. Behind the output register
// sits a one-item skid register; req_stall rises only when that skid
// register holds an item, i.e. after rsp has been stalled, and drops in the
// cycle after rsp is taken. Status reports ok, saturation, or division by
// zero (then both parts are zero).
module complex_arithmetic_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cau_pkg::cau_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cau_pkg::cau_out_t rsp
);
    import cau_pkg::*;

    logic     en;
    logic     stg_v [QW+1];
    iter_t    stg   [QW+1];
    logic     tail_v;
    cau_out_t tail;

    logic     take;
    logic     rsp_valid_reg, rsp_valid_next;
    cau_out_t rsp_reg, rsp_next;
    logic     skid_v_reg, skid_v_next;
    cau_out_t skid_reg, skid_next;

    // advance the whole pipe unless the skid register is occupied
    assign en        = !skid_v_reg;
    assign req_stall = skid_v_reg;

    cau_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_item   (req),
        .out_valid (stg_v[0]),
        .out_item  (stg[0])
    );

    // one quotient / root bit per stage
    for (genvar i = 0; i < QW; i++)
    begin : g_iter
        cau_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_v[i]),
            .in_item   (stg[i]),
            .out_valid (stg_v[i+1]),
            .out_item  (stg[i+1])
        );
    end

    cau_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stg_v[QW]),
        .in_item   (stg[QW]),
        .out_valid (tail_v),
        .out_item  (tail)
    );

    // output register with skid: drain the skid first, else load the tail;
    // when rsp is held, park the tail item in the skid register
    assign take = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        skid_v_next    = skid_v_reg;
        skid_next      = skid_reg;
        if (take)
        begin
            if (skid_v_reg)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = skid_reg;
                skid_v_next    = 1'b0;
            end
            else
            begin
                rsp_valid_next = tail_v;
                rsp_next       = tail;
            end
        end
        else if (!skid_v_reg)
        begin
            skid_v_next = tail_v;
            skid_next   = tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            skid_v_reg    <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/cau_checker.sv =====
// ============================================================================
// cau_checker: port-level checks for the complex arithmetic unit
// Watches the request and response handshakes and the result status.
// ============================================================================
module cau_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input cau_pkg::cau_out_t rsp
);
    import cau_pkg::*;

    // a held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // request side backs up only after the response side has been held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> $past(rsp_valid && rsp_stall))
        else $error("req_stall without a held response");

    // once rsp moves, the skid item drains and req_stall is low in the next cycle
    a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall && !rsp_stall |=> !req_stall)
        else $error("req_stall stuck after rsp taken");

    // division by zero returns zero
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIVZ |-> rsp.res_re == '0 && rsp.res_im == '0)
        else $error("division by zero with nonzero result");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
